### sv/gae_pkg.sv
// shared constants, types and factor helpers for the advantage estimator
package gae_pkg;

	// factor format: unsigned Q0.16 held in 17 bits so that 1.0 fits
	localparam int FACTOR_BITS = 16;
	localparam int FACTOR_W    = FACTOR_BITS + 1;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = FACTOR_W;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [FACTOR_W-1:0] factor_t;

	localparam factor_t FACTOR_ONE     = factor_t'(1 << FACTOR_BITS);
	localparam factor_t ROUND_HALF     = factor_t'(1 << (FACTOR_BITS - 1));
	localparam factor_t DISCOUNT_RESET = factor_t'(65208);
	localparam factor_t DECAY_RESET    = factor_t'(62259);

	// register indexes of the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DISCOUNT = 2'd0,
		REG_DECAY    = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		factor_t discount;
		factor_t decay;
	} cfg_t;

	// factors above one are used as one
	function automatic factor_t clamp_factor(input factor_t f);
		return (f > FACTOR_ONE) ? FACTOR_ONE : f;
	endfunction

	// gamma * lambda in Q0.16, rounded half up
	function automatic factor_t product_factor(input factor_t g, input factor_t l);
		logic [2*FACTOR_W-1:0] p;
		p = {{FACTOR_W{1'b0}}, g} * {{FACTOR_W{1'b0}}, l};
		p = p + {{FACTOR_W{1'b0}}, ROUND_HALF};
		return p[FACTOR_BITS +: FACTOR_W];
	endfunction

	localparam factor_t GL_RESET = product_factor(DISCOUNT_RESET, DECAY_RESET);

endpackage

### sv/gae_in_if.sv
// transition channel: one rollout transition per transaction
interface gae_in_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] reward;
	logic signed [VALUE_WIDTH-1:0] state_value;
	logic                          segment_start;
	logic signed [VALUE_WIDTH-1:0] bootstrap_value;

	modport source (
		output valid, reward, state_value, segment_start, bootstrap_value,
		input  ready
	);

	modport sink (
		input  valid, reward, state_value, segment_start, bootstrap_value,
		output ready
	);
endinterface

### sv/gae_out_if.sv
// estimate channel: one advantage result per transaction
interface gae_out_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] advantage;
	logic signed [VALUE_WIDTH-1:0] target_value;
	logic                          overflow;

	modport source (
		output valid, advantage, target_value, overflow,
		input  ready
	);

	modport sink (
		input  valid, advantage, target_value, overflow,
		output ready
	);
endinterface

### sv/gae_advantage_estimator.sv
// top level of the generalized advantage estimator
//
// transition channel (sink): reward, state_value, segment_start and
// bootstrap_value of one transition, newest transition first. A transition
// with segment_start set loads bootstrap_value as the next value and clears
// the running advantage before its own step.
// estimate channel (source): advantage, target_value and overflow, one
// transaction per transition, in order.
// configuration: cfg_wr_en, cfg_index, cfg_data write discount_factor
// (index 0) or trace_decay (index 1), Q0.16 with values above 1.0 used as 1.0;
// write only while no transition is in flight.
// throughput: one transition per cycle while the estimate channel accepts.
// The td error is formed as the transition is taken, a two-entry queue
// follows, and the advantage recurrence (one multiply and add on the running
// advantage, held in adv_s1) closes in the recurrence stage, whose result
// is offered on the estimate channel from the output register.
// reset: the queue and stages empty, the state values clear to zero and the
// factors return to their defaults. A stalled receiver fills the output
// register, the recurrence stage and then the queue, after which
// transition.ready drops; nothing is lost.
module gae_advantage_estimator
	import gae_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	gae_in_if.sink                 transition,
	gae_out_if.source              estimate,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ENTRY_W = 2 * VALUE_WIDTH + 2;

	cfg_t               cfg_q;
	logic               push_valid;
	logic               push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               pop_valid;
	logic               pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.discount <= DISCOUNT_RESET;
			cfg_q.decay    <= DECAY_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DISCOUNT: cfg_q.discount <= cfg_data;
				REG_DECAY:    cfg_q.decay    <= cfg_data;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	gae_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.transition (transition),
		.discount   (cfg_q.discount),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	gae_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	gae_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.estimate  (estimate)
	);

endmodule

### sv/gae_fifo.sv
// short register queue between the front and back parts
module gae_fifo
	import gae_pkg::*;
#(
	parameter int WIDTH = 66,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;
	logic             pop_fire;

	// handshake status
	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");

	a_pop_only_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire && !push_fire |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count not reduced after a pop");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push_fire && !pop_fire |=> pop_valid)
		else $error("pushed transaction not visible at the read side");

endmodule

### sv/gae_front.sv
// front part: takes transitions, tracks the next value and forms the td error
module gae_front
	import gae_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	gae_in_if.sink                     transition,
	input  factor_t                    discount,
	output logic                       push_valid,
	input  logic                       push_ready,
	output logic [2*VALUE_WIDTH+1:0]   push_data
);

	localparam int W  = VALUE_WIDTH;
	localparam int PW = W + FACTOR_W + 1;
	localparam int SW = W + 3;
	localparam logic [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]    later_val_q;
	logic [W-1:0]    later_val;
	factor_t         gamma;
	logic [PW-1:0]   prod;
	logic [PW-1:0]   prod_rnd;
	logic [W+1:0]    scaled;
	logic [SW-1:0]   delta_sum;
	logic [W-1:0]    delta;
	logic            delta_ovf;
	logic            accept;

	assign transition.ready = push_ready;
	assign push_valid       = transition.valid;
	assign accept           = transition.valid && transition.ready;

	// td error: reward + gamma * next value - state value, saturated
	always_comb begin
		gamma      = clamp_factor(discount);
		later_val  = transition.segment_start ? transition.bootstrap_value : later_val_q;
		prod       = {{(FACTOR_W+1){later_val[W-1]}}, later_val}
			* {{(W+1){1'b0}}, gamma};
		prod_rnd   = prod + {{(PW-FACTOR_W){1'b0}}, ROUND_HALF};
		scaled     = prod_rnd[PW-1:FACTOR_BITS];
		delta_sum  = {{3{transition.reward[W-1]}}, transition.reward}
			+ {scaled[W+1], scaled}
			- {{3{transition.state_value[W-1]}}, transition.state_value};
		delta_ovf  = !((&delta_sum[SW-1:W-1]) || !(|delta_sum[SW-1:W-1]));
		if (delta_ovf) begin
			delta = delta_sum[SW-1] ? VAL_MIN : VAL_MAX;
		end else begin
			delta = delta_sum[W-1:0];
		end
	end

	// queue entry: start, delta overflow, state value, delta
	assign push_data = {transition.segment_start, delta_ovf, transition.state_value, delta};

	// value of the later transition for the next step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			later_val_q <= '0;
		end else if (accept) begin
			later_val_q <= transition.state_value;
		end
	end

endmodule

### sv/gae_back.sv
// back part: advantage recurrence, value target and output register
module gae_back
	import gae_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       pop_valid,
	output logic                       pop_ready,
	input  logic [2*VALUE_WIDTH+1:0]   pop_data,
	gae_out_if.source                  estimate
);

	localparam int W  = VALUE_WIDTH;
	localparam int PW = W + FACTOR_W + 1;
	localparam int SW = W + 3;
	localparam logic [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

	factor_t         gl_q;
	logic            pop_start;
	logic            pop_delta_ovf;
	logic [W-1:0]    pop_value;
	logic [W-1:0]    pop_delta;
	logic            pop_fire;

	logic            vld_s1;
	logic [W-1:0]    adv_s1;
	logic [W-1:0]    value_s1;
	logic            ovf_s1;

	logic            vld_s2;
	logic [W-1:0]    adv_s2;
	logic [W-1:0]    target_s2;
	logic            ovf_s2;

	logic            s1_free;
	logic            s2_free;
	logic [W-1:0]    running;
	logic [PW-1:0]   prod;
	logic [PW-1:0]   prod_rnd;
	logic [W+1:0]    scaled;
	logic [SW-1:0]   adv_sum;
	logic [W-1:0]    adv_new;
	logic            adv_ovf;
	logic [W:0]      tgt_sum;
	logic [W-1:0]    tgt_new;
	logic            tgt_ovf;

	assign {pop_start, pop_delta_ovf, pop_value, pop_delta} = pop_data;

	// stage flow
	assign s2_free   = !vld_s2 || estimate.ready;
	assign s1_free   = !vld_s1 || s2_free;
	assign pop_ready = s1_free;
	assign pop_fire  = pop_valid && pop_ready;

	// combined decay factor, refreshed every cycle from the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gl_q <= GL_RESET;
		end else begin
			gl_q <= product_factor(clamp_factor(cfg.discount), clamp_factor(cfg.decay));
		end
	end

	// advantage: delta + gamma*lambda * running advantage, saturated
	always_comb begin
		running  = pop_start ? '0 : adv_s1;
		prod     = {{(FACTOR_W+1){running[W-1]}}, running} * {{(W+1){1'b0}}, gl_q};
		prod_rnd = prod + {{(PW-FACTOR_W){1'b0}}, ROUND_HALF};
		scaled   = prod_rnd[PW-1:FACTOR_BITS];
		adv_sum  = {{3{pop_delta[W-1]}}, pop_delta} + {scaled[W+1], scaled};
		adv_ovf  = !((&adv_sum[SW-1:W-1]) || !(|adv_sum[SW-1:W-1]));
		if (adv_ovf) begin
			adv_new = adv_sum[SW-1] ? VAL_MIN : VAL_MAX;
		end else begin
			adv_new = adv_sum[W-1:0];
		end
	end

	// value target: advantage + state value, saturated
	always_comb begin
		tgt_sum = {adv_s1[W-1], adv_s1} + {value_s1[W-1], value_s1};
		tgt_ovf = (tgt_sum[W] != tgt_sum[W-1]);
		if (tgt_ovf) begin
			tgt_new = tgt_sum[W] ? VAL_MIN : VAL_MAX;
		end else begin
			tgt_new = tgt_sum[W-1:0];
		end
	end

	// recurrence stage; adv_s1 also holds the running advantage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			adv_s1 <= '0;
		end else begin
			if (s1_free) begin
				vld_s1 <= pop_valid;
			end
			if (pop_fire) begin
				adv_s1 <= adv_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			value_s1 <= pop_value;
			ovf_s1   <= pop_delta_ovf || adv_ovf;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && s2_free) begin
			adv_s2    <= adv_s1;
			target_s2 <= tgt_new;
			ovf_s2    <= ovf_s1 || tgt_ovf;
		end
	end

	assign estimate.valid        = vld_s2;
	assign estimate.advantage    = adv_s2;
	assign estimate.target_value = target_s2;
	assign estimate.overflow     = ovf_s2;

	a_gl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gl_q <= FACTOR_ONE)
		else $error("combined decay factor above one");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s2_free |=> vld_s1 && $stable(adv_s1))
		else $error("recurrence stage lost a transaction under stall");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire && pop_start |=> adv_s1 == $past(pop_delta))
		else $error("segment start did not clear the running advantage");

endmodule

### tb/gae_advantage_estimator_tb.sv
// self-checking testbench for the generalized advantage estimator
module gae_advantage_estimator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gae_pkg::*;

	localparam int VALUE_W        = 32;
	localparam int TAIL_CYCLES    = 4;
	localparam int WATCHDOG_LIMIT = 1000;

	localparam logic signed [VALUE_W-1:0] FIXED_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] FIXED_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] FIXED_ONE = 32'sd65536;
	localparam longint SAT_HI = (longint'(1) <<< (VALUE_W-1)) - 1;
	localparam longint SAT_LO = -(longint'(1) <<< (VALUE_W-1));

	// largest raw register value and the two indexes that map to no register
	localparam factor_t FACTOR_RAW_MAX = {FACTOR_W{1'b1}};
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		logic signed [VALUE_W-1:0] reward;
		logic signed [VALUE_W-1:0] state_value;
		logic                      segment_start;
		logic signed [VALUE_W-1:0] bootstrap_value;
	} transition_t;

	typedef struct {
		logic signed [VALUE_W-1:0] advantage;
		logic signed [VALUE_W-1:0] target_value;
		logic                      overflow;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gae_in_if #(.VALUE_WIDTH(VALUE_W)) transition_ch ();
	gae_out_if #(.VALUE_WIDTH(VALUE_W)) estimate_ch ();

	gae_advantage_estimator #(.VALUE_WIDTH(VALUE_W)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.transition (transition_ch),
		.estimate   (estimate_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// estimator copy: factor registers and recursion state
	factor_t discount_q = DISCOUNT_RESET;
	factor_t decay_q    = DECAY_RESET;
	longint  running_adv = 0;
	longint  next_val    = 0;

	estimate_t pending_estimates[$];

	bit send_idling = 1'b0;
	bit recv_idling = 1'b0;
	int stall_left  = 0;
	int idle_cycles = 0;
	int errors      = 0;
	int transitions_sent  = 0;
	int segments_started  = 0;
	int estimates_checked = 0;
	int overflows_seen    = 0;
	int factor_settings   = 1;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// value times Q0.16 factor, rounded half toward plus infinity
	function automatic longint scale_by_factor(input longint v, input longint f);
		return (v * f + 32768) >>> FACTOR_BITS;
	endfunction

	function automatic longint saturate_fixed(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// one recursion step, updates the running state
	function automatic estimate_t predict_estimate(input transition_t t);
		estimate_t e;
		longint gamma, lambda, gl;
		longint delta_raw, delta, adv_raw, adv, target_raw, target;
		gamma  = (discount_q > FACTOR_ONE) ? longint'(FACTOR_ONE) : longint'(discount_q);
		lambda = (decay_q > FACTOR_ONE) ? longint'(FACTOR_ONE) : longint'(decay_q);
		gl     = (gamma * lambda + 32768) >> FACTOR_BITS;
		if (t.segment_start) begin
			running_adv = 0;
			next_val    = longint'(t.bootstrap_value);
		end
		delta_raw  = longint'(t.reward) + scale_by_factor(next_val, gamma)
			- longint'(t.state_value);
		delta      = saturate_fixed(delta_raw);
		adv_raw    = delta + scale_by_factor(running_adv, gl);
		adv        = saturate_fixed(adv_raw);
		target_raw = adv + longint'(t.state_value);
		target     = saturate_fixed(target_raw);
		running_adv = adv;
		next_val    = longint'(t.state_value);
		e.advantage    = adv[VALUE_W-1:0];
		e.target_value = target[VALUE_W-1:0];
		e.overflow     = (delta != delta_raw) || (adv != adv_raw) || (target != target_raw);
		return e;
	endfunction

	function automatic transition_t make_transition(input logic start,
			input logic signed [VALUE_W-1:0] reward, input logic signed [VALUE_W-1:0] value,
			input logic signed [VALUE_W-1:0] boot);
		transition_t t;
		t.segment_start   = start;
		t.reward          = reward;
		t.state_value     = value;
		t.bootstrap_value = boot;
		return t;
	endfunction

	// mostly moderate magnitudes, some full range and rail values
	function automatic logic signed [VALUE_W-1:0] random_fixed();
		logic signed [VALUE_W-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 19))
			0: begin
				return FIXED_MAX;
			end
			1: begin
				return FIXED_MIN;
			end
			2, 3: begin
				return v;
			end
			default: begin
				return v >>> $urandom_range(4, 24);
			end
		endcase
	endfunction

	// compare one estimate transaction with the oldest prediction
	task automatic check_estimate();
		estimate_t exp_e;
		if (pending_estimates.size() == 0) begin
			$error("estimate with nothing pending: advantage %0d target_value %0d",
				estimate_ch.advantage, estimate_ch.target_value);
			errors++;
		end else begin
			exp_e = pending_estimates.pop_front();
			estimates_checked++;
			if (estimate_ch.overflow === 1'b1)
				overflows_seen++;
			if (estimate_ch.advantage !== exp_e.advantage) begin
				$error("advantage: expected %0d, got %0d", exp_e.advantage,
					estimate_ch.advantage);
				errors++;
			end
			if (estimate_ch.target_value !== exp_e.target_value) begin
				$error("target_value: expected %0d, got %0d", exp_e.target_value,
					estimate_ch.target_value);
				errors++;
			end
			if (estimate_ch.overflow !== exp_e.overflow) begin
				$error("overflow: expected %0d, got %0d", exp_e.overflow,
					estimate_ch.overflow);
				errors++;
			end
		end
	endtask

	// receiver: check accepted transactions, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && estimate_ch.valid && estimate_ch.ready)
			check_estimate();
		if (stall_left > 0) begin
			stall_left--;
			estimate_ch.ready <= 1'b0;
		end else if (recv_idling && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 11);
			estimate_ch.ready <= 1'b0;
		end else begin
			estimate_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (transition_ch.valid && transition_ch.ready)
				|| (estimate_ch.valid && estimate_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction, %0d estimates pending",
				idle_cycles, pending_estimates.size());
			$display("gae_advantage_estimator_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// send one transition, with an optional random gap before it
	task automatic send_transition(input transition_t t);
		if (send_idling && $urandom_range(0, 5) == 0) begin
			transition_ch.valid           <= 1'b0;
			transition_ch.reward          <= $urandom;
			transition_ch.state_value     <= $urandom;
			transition_ch.segment_start   <= 1'($urandom_range(0, 1));
			transition_ch.bootstrap_value <= $urandom;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		transition_ch.valid           <= 1'b1;
		transition_ch.reward          <= t.reward;
		transition_ch.state_value     <= t.state_value;
		transition_ch.segment_start   <= t.segment_start;
		transition_ch.bootstrap_value <= t.bootstrap_value;
		@(posedge clk);
		while (!transition_ch.ready)
			@(posedge clk);
		pending_estimates.insert(pending_estimates.size(), predict_estimate(t));
		transitions_sent++;
		if (t.segment_start)
			segments_started++;
	endtask

	// stop sending and wait until every predicted estimate has arrived
	task automatic drain_estimates();
		transition_ch.valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// single register write, block must be idle
	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input factor_t value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_DISCOUNT: discount_q = value;
			REG_DECAY:    decay_q    = value;
			default:      ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_factors(input factor_t gamma, input factor_t lambda);
		drain_estimates();
		write_register(REG_DISCOUNT, gamma);
		write_register(REG_DECAY, lambda);
		factor_settings++;
	endtask

	// default factors: no start after reset, rails and saturation both ways
	task automatic test_reset_defaults();
		send_idling = 1'b1;
		recv_idling = 1'b1;
		send_transition(make_transition(1'b0, FIXED_ONE, FIXED_ONE >>> 1, FIXED_MAX));
		send_transition(make_transition(1'b1, FIXED_MAX, FIXED_MIN, FIXED_MAX));
		send_transition(make_transition(1'b0, FIXED_MIN, FIXED_MAX, 32'sd0));
		send_transition(make_transition(1'b1, FIXED_MIN, FIXED_MAX, FIXED_MIN));
		send_transition(make_transition(1'b1, 32'sd0, 32'sd0, 32'sd0));
		send_transition(make_transition(1'b0, FIXED_MAX, FIXED_MAX, FIXED_MIN));
		send_transition(make_transition(1'b0, FIXED_MIN, FIXED_MIN, FIXED_MAX));
		send_transition(make_transition(1'b1, -32'sd1, 32'sd1, -32'sd1));
	endtask

	// half-way products of single lsb values, both signs
	task automatic test_tie_rounding();
		set_factors(factor_t'(32768), FACTOR_ONE);
		send_transition(make_transition(1'b1, 32'sd0, 32'sd0, 32'sd1));
		send_transition(make_transition(1'b1, 32'sd0, 32'sd0, -32'sd1));
		send_transition(make_transition(1'b1, 32'sd0, 32'sd0, 32'sd3));
		send_transition(make_transition(1'b1, 32'sd0, 32'sd0, -32'sd3));
		send_transition(make_transition(1'b0, 32'sd1, -32'sd1, 32'sd0));
		send_transition(make_transition(1'b0, -32'sd1, 32'sd1, 32'sd0));
	endtask

	// zero, unity and above-unity factors
	task automatic test_factor_extremes();
		factor_t gammas[4];
		factor_t lambdas[4];
		gammas  = '{factor_t'(0), FACTOR_ONE, FACTOR_RAW_MAX, factor_t'(1)};
		lambdas = '{factor_t'(0), FACTOR_ONE, factor_t'(65537), factor_t'(65535)};
		for (int k = 0; k < 4; k++) begin
			set_factors(gammas[k], lambdas[k]);
			send_transition(make_transition(1'b1, random_fixed(), random_fixed(),
				random_fixed()));
			send_transition(make_transition(1'b0, random_fixed(), random_fixed(),
				random_fixed()));
		end
	endtask

	// writes to indexes without a register leave the factors alone
	task automatic test_unused_registers();
		drain_estimates();
		write_register(REG_SPARE_LO, factor_t'(0));
		write_register(REG_SPARE_HI, FACTOR_RAW_MAX);
		send_transition(make_transition(1'b1, random_fixed(), random_fixed(), random_fixed()));
		send_transition(make_transition(1'b0, random_fixed(), random_fixed(), random_fixed()));
	endtask

	// random segments over several factor settings, idling varied per segment
	task automatic test_random_segments(input int item_count);
		int sent;
		int seg_len;
		int phase_quota;
		logic [1:0] idle_mode;
		logic start;
		sent = 0;
		phase_quota = item_count / 8;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_factors(DISCOUNT_RESET, DECAY_RESET);
				1: set_factors(FACTOR_ONE, FACTOR_ONE);
				2: set_factors(factor_t'(0), factor_t'($urandom_range(0, 65536)));
				3: set_factors(FACTOR_RAW_MAX, FACTOR_RAW_MAX);
				4: set_factors(factor_t'($urandom_range(0, 131071)),
					factor_t'($urandom_range(0, 131071)));
				default: set_factors(factor_t'($urandom_range(55000, 65536)),
					factor_t'($urandom_range(40000, 65536)));
			endcase
			while (sent < phase_quota * (phase + 1)) begin
				idle_mode   = 2'($urandom_range(0, 3));
				send_idling = idle_mode[0];
				recv_idling = idle_mode[1];
				seg_len = $urandom_range(1, 48);
				for (int i = 0; i < seg_len; i++) begin
					// mostly clean segments, sometimes a missing or stray start
					if (i == 0)
						start = ($urandom_range(0, 9) != 0);
					else
						start = ($urandom_range(0, 31) == 0);
					send_transition(make_transition(start, random_fixed(),
						random_fixed(), random_fixed()));
					sent++;
				end
			end
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_back_to_back(input int item_count);
		send_idling = 1'b0;
		recv_idling = 1'b0;
		drain_estimates();
		while (stall_left > 0)
			@(posedge clk);
		for (int i = 0; i < item_count; i++)
			send_transition(make_transition((i % 25) == 0, random_fixed(), random_fixed(),
				random_fixed()));
	endtask

	initial begin
		transition_ch.valid           <= 1'b0;
		transition_ch.reward          <= '0;
		transition_ch.state_value     <= '0;
		transition_ch.segment_start   <= 1'b0;
		transition_ch.bootstrap_value <= '0;
		cfg_wr_en                     <= 1'b0;
		cfg_index                     <= REG_DISCOUNT;
		cfg_data                      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_tie_rounding();
		test_factor_extremes();
		test_unused_registers();
		test_random_segments(1580);
		test_back_to_back(50);
		drain_estimates();

		$display("covered %0d transitions in %0d segments under %0d factor settings",
			transitions_sent, segments_started, factor_settings);
		$display("%0d estimates checked, %0d of them with overflow raised",
			estimates_checked, overflows_seen);
		if (errors == 0)
			$display("gae_advantage_estimator_tb: clean");
		else
			$display("gae_advantage_estimator_tb: errors");
		$finish;
	end

endmodule
